// File: rtl/balance_robot_cascade_controller_macros.svh
// Assertion macros for the balance controller.
// Plain header, no dependencies; included by the controller, which checks itself.
`ifndef BALANCE_ROBOT_CASCADE_CONTROLLER_MACROS_SVH
`define BALANCE_ROBOT_CASCADE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checking suspended while reset is held
`define BRCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checking suspended while reset is held
`define BRCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/brcc_pkg.sv
// Package for the balance controller: field widths, register codes,
// reset values, sequencer types. No dependencies.
`default_nettype none

package brcc_pkg;

    // fixed-point format of the speed state
    localparam int FRACTION_BITS_DEF = 8;

    // request and result field widths
    localparam int ANGLE_W = 17;
    localparam int RATE_W  = 16;
    localparam int COUNT_W = 16;
    localparam int DRIVE_W = 14;
    localparam int PWM_W   = 14;
    localparam int BIAS_W  = ANGLE_W + 1;
    localparam int SUM_W   = COUNT_W + 1;

    // configuration register widths
    localparam int CENTER_W   = 17;
    localparam int BKP_W      = 12;
    localparam int BKD_W      = 16;
    localparam int SKP_W      = 10;
    localparam int SKI_W      = 16;
    localparam int OLIM_W     = 13;
    localparam int TLIM_W     = 16;
    localparam int POFF_W     = 12;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;

    // configuration reset values
    localparam int CENTER_RST = 0;
    localparam int BKP_RST    = 800;
    localparam int BKD_RST    = 819;
    localparam int SKP_RST    = 90;
    localparam int SKI_RST    = 128;
    localparam int OLIM_RST   = 6900;
    localparam int TLIM_RST   = 10240;
    localparam int POFF_RST   = 2500;

    // serial multiplier: 16-bit multiplier operand, one 4-bit digit per cycle
    localparam int MUL_W    = 16;
    localparam int DIGIT_W  = 4;
    localparam int N_DIGITS = MUL_W / DIGIT_W;
    localparam int CNT_W    = $clog2(N_DIGITS);

    // filter and loop constants
    localparam int FILT_OLD       = 205;
    localparam int FILT_NEW       = 51;
    localparam int FILT_SHIFT     = 8;
    localparam int BAL_SHIFT      = 8;
    localparam int INTEGRAL_LIMIT = 10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_ANGLE = 3'd0,
        CFG_BALANCE_KP   = 3'd1,
        CFG_BALANCE_KD   = 3'd2,
        CFG_SPEED_KP     = 3'd3,
        CFG_SPEED_KI     = 3'd4,
        CFG_OUTPUT_LIMIT = 3'd5,
        CFG_TILT_LIMIT   = 3'd6,
        CFG_PWM_OFFSET   = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_COMB,
        ST_ROUND,
        ST_INTEG,
        ST_DRIVE,
        ST_CLAMP,
        ST_OUT
    } t_state;

    // which product the shared multiplier is working on
    typedef enum logic [2:0] {
        PR_FILT_OLD,
        PR_FILT_NEW,
        PR_BAL_P,
        PR_BAL_D,
        PR_VEL_P,
        PR_VEL_I
    } t_prod;

endpackage

`default_nettype wire

// File: rtl/balance_robot_cascade_controller.sv
// Balance controller: PD tilt loop and PI wheel-speed loop on a shared
// digit-serial multiplier. Uses brcc_pkg and the assertion macro header.
//
// Usage:
//   Request channel i_valid/o_ready carries tilt angle, gyro rate and the two
//   encoder counts; one result (drive value, direction, PWM compare, stop
//   flag) comes back on o_valid/i_ready for every request.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data, one
//   register per write; the user must write only while no request is in
//   flight, as the block itself does not enforce it. A new request is taken
//   only in idle, once the last result has moved to the output register.
//   The run is set by the one multiplier: six products, each taking one
//   operand load, four 4-bit gain digits and one combine step, plus three
//   rounding steps and the integral, drive, clamp and output stages.
//   Reset (synchronous, active low) restores the default gains and limits
//   and clears the filtered speed and the speed integral.
//   A result waits in the output register while i_ready is low; the block
//   still accepts and works on the next request, and holds it in its last
//   stage until the output register is free.
`default_nettype none
`include "balance_robot_cascade_controller_macros.svh"

module balance_robot_cascade_controller
    import brcc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [ANGLE_W-1:0]  i_tilt_angle,
    input  logic signed [RATE_W-1:0]   i_tilt_rate,
    input  logic signed [COUNT_W-1:0]  i_left_count,
    input  logic signed [COUNT_W-1:0]  i_right_count,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [DRIVE_W-1:0]  o_drive_value,
    output logic                       o_reverse,
    output logic [PWM_W-1:0]           o_pwm_compare,
    output logic                       o_stopped
);

    // state and datapath widths follow from the fraction bits
    localparam int FILT_W      = FRACTION_BITS + 18;
    localparam int INTEG_W     = FRACTION_BITS + 16;
    localparam int INTEG_SUM_W = FRACTION_BITS + 19;
    localparam int MC_W        = FILT_W;
    localparam int PROD_W      = MC_W + 1 + MUL_W;
    localparam int PART_W      = MC_W + DIGIT_W + 1;
    localparam int SH_MAX      = (FRACTION_BITS > BAL_SHIFT) ? FRACTION_BITS : BAL_SHIFT;
    localparam int ACC_W       = PROD_W + SH_MAX + 1;
    localparam int VEL_SHIFT   = FRACTION_BITS + BAL_SHIFT;

    localparam logic signed [INTEG_SUM_W-1:0] INTEG_LIM =
        INTEG_SUM_W'(longint'(INTEGRAL_LIMIT) << FRACTION_BITS);
    localparam logic signed [INTEG_SUM_W-1:0] INTEG_LIM_NEG = -INTEG_LIM;

    localparam logic signed [ACC_W-1:0] MASK_FILT =
        {{(ACC_W-FILT_SHIFT){1'b0}}, {FILT_SHIFT{1'b1}}};
    localparam logic signed [ACC_W-1:0] MASK_BAL =
        {{(ACC_W-BAL_SHIFT){1'b0}}, {BAL_SHIFT{1'b1}}};
    localparam logic signed [ACC_W-1:0] MASK_VEL =
        {{(ACC_W-VEL_SHIFT){1'b0}}, {VEL_SHIFT{1'b1}}};

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_DIGITS - 1);

    // configuration registers
    logic signed [CENTER_W-1:0] r_center;
    logic [BKP_W-1:0]           r_bkp;
    logic [BKD_W-1:0]           r_bkd;
    logic [SKP_W-1:0]           r_skp;
    logic [SKI_W-1:0]           r_ski;
    logic [OLIM_W-1:0]          r_olim;
    logic [TLIM_W-1:0]          r_tlim;
    logic [POFF_W-1:0]          r_poff;

    // sequencer
    t_state           r_state, n_state;
    t_prod            r_prod, n_prod;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // loop state
    logic signed [FILT_W-1:0]  r_filt, n_filt;
    logic signed [INTEG_W-1:0] r_integ, n_integ;

    // latched request
    logic signed [BIAS_W-1:0]  r_bias, n_bias;
    logic signed [RATE_W-1:0]  r_rate, n_rate;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [ANGLE_W-1:0] r_angle, n_angle;

    // serial multiplier: parallel multiplicand, multiplier shifted out a digit a cycle
    logic signed [MC_W-1:0]  r_md, n_md;
    logic [MUL_W-1:0]        r_mr, n_mr;
    logic signed [MC_W:0]    r_ph, n_ph;
    logic [MUL_W-1:0]        r_pl, n_pl;
    logic signed [PART_W-1:0] mul_part, mul_sum;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;

    // accumulation, rounding and drive
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic signed [ACC_W-1:0]       r_bal, n_bal;
    logic signed [ACC_W-1:0]       rnd_mask, rnd_sum;
    logic signed [INTEG_SUM_W-1:0] integ_sum;
    logic signed [ACC_W-1:0]       lim_pos, lim_neg;
    logic signed [BIAS_W-1:0]      tlim_pos, tlim_neg, angle_ext;
    logic signed [DRIVE_W-1:0]     r_drive, n_drive;
    logic                          r_stop, n_stop;
    logic [DRIVE_W-1:0]            drive_mag;

    // result register
    logic                      r_ovalid;
    logic signed [DRIVE_W-1:0] r_odrive;
    logic                      r_orev;
    logic [PWM_W-1:0]          r_opwm;
    logic                      r_ostop;

    logic in_acc;
    logic out_load;

    assign o_ready  = (r_state == ST_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == ST_OUT) && (!r_ovalid || i_ready);

    // one digit step of the multiplier, and the finished product
    assign mul_part = r_md * $signed({1'b0, r_mr[DIGIT_W-1:0]});
    assign mul_sum  = PART_W'(r_ph) + mul_part;
    assign prod     = $signed({r_ph, r_pl});
    assign prod_ext = ACC_W'(prod);

    // round toward zero: bias negative values up before the arithmetic shift
    always_comb begin
        case (r_prod)
            PR_FILT_NEW: rnd_mask = MASK_FILT;
            PR_BAL_D:    rnd_mask = MASK_BAL;
            PR_VEL_I:    rnd_mask = MASK_VEL;
            default:     rnd_mask = '0;
        endcase
        rnd_sum = r_acc + (r_acc[ACC_W-1] ? rnd_mask : '0);
    end

    assign integ_sum = INTEG_SUM_W'(r_integ) + INTEG_SUM_W'(r_filt);
    assign lim_pos   = ACC_W'({1'b0, r_olim});
    assign lim_neg   = -lim_pos;
    assign tlim_pos  = BIAS_W'({1'b0, r_tlim});
    assign tlim_neg  = -tlim_pos;
    assign angle_ext = BIAS_W'(r_angle);
    assign drive_mag = r_drive[DRIVE_W-1] ? DRIVE_W'(-r_drive) : r_drive;

    // next state of the sequencer
    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_LOAD;
                    n_prod  = PR_FILT_OLD;
                end
            end
            ST_LOAD: begin
                n_state = ST_MUL;
                n_cnt   = '0;
            end
            ST_MUL: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_COMB;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_COMB: begin
                case (r_prod)
                    PR_FILT_OLD: begin
                        n_state = ST_LOAD;
                        n_prod  = PR_FILT_NEW;
                    end
                    PR_BAL_P: begin
                        n_state = ST_LOAD;
                        n_prod  = PR_BAL_D;
                    end
                    PR_VEL_P: begin
                        n_state = ST_LOAD;
                        n_prod  = PR_VEL_I;
                    end
                    PR_FILT_NEW, PR_BAL_D, PR_VEL_I: n_state = ST_ROUND;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_ROUND: begin
                case (r_prod)
                    PR_FILT_NEW: n_state = ST_INTEG;
                    PR_BAL_D: begin
                        n_state = ST_LOAD;
                        n_prod  = PR_VEL_P;
                    end
                    PR_VEL_I: n_state = ST_DRIVE;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_INTEG: begin
                n_state = ST_LOAD;
                n_prod  = PR_BAL_P;
            end
            ST_DRIVE: n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values per stage
    always_comb begin
        n_bias  = r_bias;
        n_rate  = r_rate;
        n_sum   = r_sum;
        n_angle = r_angle;
        n_md    = r_md;
        n_mr    = r_mr;
        n_ph    = r_ph;
        n_pl    = r_pl;
        n_acc   = r_acc;
        n_bal   = r_bal;
        n_filt  = r_filt;
        n_integ = r_integ;
        n_drive = r_drive;
        n_stop  = r_stop;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_bias  = BIAS_W'(i_tilt_angle) - BIAS_W'(r_center);
                    n_rate  = i_tilt_rate;
                    n_sum   = SUM_W'(i_left_count) + SUM_W'(i_right_count);
                    n_angle = i_tilt_angle;
                end
            end
            ST_LOAD: begin
                // pick operands for the product in hand
                n_ph = '0;
                n_pl = '0;
                case (r_prod)
                    PR_FILT_OLD: begin
                        n_md = MC_W'(r_filt);
                        n_mr = MUL_W'(FILT_OLD);
                    end
                    PR_FILT_NEW: begin
                        n_md = MC_W'(r_sum);
                        n_mr = MUL_W'(FILT_NEW);
                    end
                    PR_BAL_P: begin
                        n_md = MC_W'(r_bias);
                        n_mr = MUL_W'(r_bkp);
                    end
                    PR_BAL_D: begin
                        n_md = MC_W'(r_rate);
                        n_mr = MUL_W'(r_bkd);
                    end
                    PR_VEL_P: begin
                        n_md = MC_W'(r_filt);
                        n_mr = MUL_W'(r_skp);
                    end
                    PR_VEL_I: begin
                        n_md = MC_W'(r_integ);
                        n_mr = MUL_W'(r_ski);
                    end
                    default: begin
                        n_md = '0;
                        n_mr = '0;
                    end
                endcase
            end
            ST_MUL: begin
                // add one digit's partial product, shift a digit into the low half
                n_ph = mul_sum[PART_W-1:DIGIT_W];
                n_pl = {mul_sum[DIGIT_W-1:0], r_pl[MUL_W-1:DIGIT_W]};
                n_mr = r_mr >> DIGIT_W;
            end
            ST_COMB: begin
                case (r_prod)
                    PR_FILT_OLD: n_acc = prod_ext;
                    PR_FILT_NEW: n_acc = r_acc + (prod_ext <<< FRACTION_BITS);
                    PR_BAL_P:    n_acc = prod_ext;
                    PR_BAL_D:    n_acc = r_acc + prod_ext;
                    PR_VEL_P:    n_acc = prod_ext <<< BAL_SHIFT;
                    PR_VEL_I:    n_acc = r_acc + prod_ext;
                    default:     n_acc = r_acc;
                endcase
            end
            ST_ROUND: begin
                case (r_prod)
                    PR_FILT_NEW: n_filt = FILT_W'(rnd_sum >>> FILT_SHIFT);
                    PR_BAL_D:    n_bal  = rnd_sum >>> BAL_SHIFT;
                    PR_VEL_I:    n_acc  = rnd_sum >>> VEL_SHIFT;
                    default:     n_acc  = r_acc;
                endcase
            end
            ST_INTEG: begin
                // integrate the filtered speed with saturation
                if (integ_sum > INTEG_LIM) begin
                    n_integ = INTEG_W'(INTEG_LIM);
                end else if (integ_sum < INTEG_LIM_NEG) begin
                    n_integ = INTEG_W'(INTEG_LIM_NEG);
                end else begin
                    n_integ = INTEG_W'(integ_sum);
                end
            end
            ST_DRIVE: begin
                n_acc = r_bal - r_acc;
            end
            ST_CLAMP: begin
                if (r_acc > lim_pos) begin
                    n_drive = DRIVE_W'(lim_pos);
                end else if (r_acc < lim_neg) begin
                    n_drive = DRIVE_W'(lim_neg);
                end else begin
                    n_drive = DRIVE_W'(r_acc);
                end
                // tilt check uses the raw angle, not the centred one
                n_stop = (angle_ext > tlim_pos) || (angle_ext < tlim_neg);
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    // control registers, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prod   <= PR_FILT_OLD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_filt   <= '0;
            r_integ  <= '0;
            r_center <= CENTER_W'(CENTER_RST);
            r_bkp    <= BKP_W'(BKP_RST);
            r_bkd    <= BKD_W'(BKD_RST);
            r_skp    <= SKP_W'(SKP_RST);
            r_ski    <= SKI_W'(SKI_RST);
            r_olim   <= OLIM_W'(OLIM_RST);
            r_tlim   <= TLIM_W'(TLIM_RST);
            r_poff   <= POFF_W'(POFF_RST);
        end else begin
            r_state <= n_state;
            r_prod  <= n_prod;
            r_cnt   <= n_cnt;
            r_filt  <= n_filt;
            r_integ <= n_integ;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CENTER_ANGLE: r_center <= i_cfg_data[CENTER_W-1:0];
                    CFG_BALANCE_KP:   r_bkp    <= i_cfg_data[BKP_W-1:0];
                    CFG_BALANCE_KD:   r_bkd    <= i_cfg_data[BKD_W-1:0];
                    CFG_SPEED_KP:     r_skp    <= i_cfg_data[SKP_W-1:0];
                    CFG_SPEED_KI:     r_ski    <= i_cfg_data[SKI_W-1:0];
                    CFG_OUTPUT_LIMIT: r_olim   <= i_cfg_data[OLIM_W-1:0];
                    CFG_TILT_LIMIT:   r_tlim   <= i_cfg_data[TLIM_W-1:0];
                    CFG_PWM_OFFSET:   r_poff   <= i_cfg_data[POFF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bias  <= n_bias;
        r_rate  <= n_rate;
        r_sum   <= n_sum;
        r_angle <= n_angle;
        r_md    <= n_md;
        r_mr    <= n_mr;
        r_ph    <= n_ph;
        r_pl    <= n_pl;
        r_acc   <= n_acc;
        r_bal   <= n_bal;
        r_drive <= n_drive;
        r_stop  <= n_stop;
        if (out_load) begin
            r_odrive <= r_drive;
            r_ostop  <= r_stop;
            r_orev   <= r_stop ? 1'b0 : r_drive[DRIVE_W-1];
            r_opwm   <= r_stop ? '0 : (PWM_W'(drive_mag) + PWM_W'(r_poff));
        end
    end

    assign o_valid       = r_ovalid;
    assign o_drive_value = r_odrive;
    assign o_reverse     = r_orev;
    assign o_pwm_compare = r_opwm;
    assign o_stopped     = r_ostop;

    // checks
    `BRCC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == ST_LOAD && r_prod == PR_FILT_OLD, "accepted request did not start the filter product")
    `BRCC_ASSERT_NOW(a_stop_blanks, i_clk, i_rst_n, o_valid && o_stopped, !o_reverse && o_pwm_compare == '0, "stopped result carries direction or PWM")
    `BRCC_ASSERT_NOW(a_dir_sign, i_clk, i_rst_n, o_valid && !o_stopped, o_reverse == o_drive_value[DRIVE_W-1], "direction bit disagrees with drive sign")
    `BRCC_ASSERT_NOW(a_integ_range, i_clk, i_rst_n, 1'b1, INTEG_SUM_W'(r_integ) <= INTEG_LIM && INTEG_SUM_W'(r_integ) >= INTEG_LIM_NEG, "speed integral beyond its clamp")
    `BRCC_ASSERT_NOW(a_cnt_idle, i_clk, i_rst_n, r_state != ST_MUL, r_cnt == '0, "digit counter running outside the multiply")

endmodule

`default_nettype wire
